>>> hw/rtl/spq_pkg.sv
// shared types and codes for the sorted min priority queue
package spq_pkg;

    localparam int DataW   = 32;
    localparam int ModeW   = 2;
    localparam int StatusW = 2;
    localparam int CountW  = 5;

    typedef enum logic [ModeW-1:0] {
        MODE_ADD  = 2'd0,
        MODE_POP  = 2'd1,
        MODE_PEEK = 2'd2
    } mode_t;

    typedef enum logic [StatusW-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY_POP = 2'd1,
        ST_FULL_DROP = 2'd2
    } status_t;

    // one stored slot as seen by a neighbor
    typedef struct packed {
        logic                    full;
        logic signed [DataW-1:0] value;
    } entry_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic                    fire;
        logic                    add;
        logic                    pop;
        logic signed [DataW-1:0] value;
    } cmd_t;

endpackage

>>> hw/rtl/spq_if.sv
// valid/ready channel interfaces for request and response transactions
interface spq_req_if;
    logic                                valid;
    logic                                ready;
    logic [spq_pkg::ModeW-1:0]           mode;
    logic signed [spq_pkg::DataW-1:0]    value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

interface spq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [spq_pkg::DataW-1:0]    head_value;
    logic                                is_empty;
    logic [spq_pkg::CountW-1:0]          entry_count;
    logic [spq_pkg::StatusW-1:0]         status;

    modport source (output valid, output head_value, output is_empty,
                    output entry_count, output status, input ready);
    modport sink (input valid, input head_value, input is_empty,
                  input entry_count, input status, output ready);
endinterface

>>> hw/rtl/spq_cell.sv
// one slot of the sorted queue: compares with the broadcast value and shifts
module spq_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  spq_pkg::cmd_t   cmd,
    input  spq_pkg::entry_t left,
    input  logic            left_gt,
    input  spq_pkg::entry_t right,
    output spq_pkg::entry_t cur,
    output logic            gt,
    output spq_pkg::entry_t nxt
);

    logic                             full_reg;
    logic signed [spq_pkg::DataW-1:0] value_reg;

    assign cur.full  = full_reg;
    assign cur.value = value_reg;

    // stored value is strictly larger than the incoming one
    assign gt = full_reg && ($signed(value_reg) > $signed(cmd.value));

    // next slot contents
    always_comb
    begin
        nxt = cur;
        if (cmd.fire && cmd.add)
        begin
            nxt.full = full_reg | left.full;
            if (left_gt)
            begin
                nxt.value = left.value;
            end
            else if (gt || !full_reg)
            begin
                nxt.value = cmd.value;
            end
        end
        else if (cmd.fire && cmd.pop)
        begin
            nxt = right;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= nxt.full;
        end
    end

    // stored value, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= nxt.value;
    end

endmodule

>>> hw/rtl/sorted_min_priority_queue.sv
// a response is registered and appears in the cycle after its request transaction is accepted
// throughput: one transaction per cycle while no response is held back; all cells compare and shift together
// a new request is taken while the previous response is taken or the output is empty
// reset clears the entry count, the cell occupancy flags and the response valid
// stored values are left uninitialized and are never read before being written
module sorted_min_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int CntW = $clog2(CAPACITY + 1);

    spq_pkg::cmd_t    cmd;
    spq_pkg::entry_t  cur [CAPACITY];
    spq_pkg::entry_t  nxt [CAPACITY];
    logic             gt [CAPACITY];
    logic [CAPACITY-1:0] full_vec;

    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;
    spq_pkg::status_t status_next;
    logic             fire;

    logic                             rsp_valid_reg;
    logic signed [spq_pkg::DataW-1:0] head_reg;
    logic                             empty_reg;
    logic [spq_pkg::CountW-1:0]       count_out_reg;
    spq_pkg::status_t                 status_reg;

    // request handshake with output register
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;

    // decode operation
    always_comb
    begin
        cmd.fire  = fire;
        cmd.add   = 1'b0;
        cmd.pop   = 1'b0;
        cmd.value = req.value;
        case (spq_pkg::mode_t'(req.mode))
            spq_pkg::MODE_ADD: cmd.add = 1'b1;
            spq_pkg::MODE_POP: cmd.pop = 1'b1;
            default:           ;
        endcase
    end

    // row of cells, head at index zero
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            spq_pkg::entry_t left_e;
            spq_pkg::entry_t right_e;
            logic            left_gt;

            if (i == 0)
            begin : g_first
                assign left_e.full  = 1'b1;
                assign left_e.value = '0;
                assign left_gt      = 1'b0;
            end
            else
            begin : g_mid
                assign left_e  = cur[i-1];
                assign left_gt = gt[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_e.full  = 1'b0;
                assign right_e.value = '0;
            end
            else
            begin : g_inner
                assign right_e = cur[i+1];
            end

            spq_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .left    (left_e),
                .left_gt (left_gt),
                .right   (right_e),
                .cur     (cur[i]),
                .gt      (gt[i]),
                .nxt     (nxt[i])
            );

            assign full_vec[i] = cur[i].full;
        end
    endgenerate

    // entry count and status
    always_comb
    begin
        count_next  = count_reg;
        status_next = spq_pkg::ST_OK;
        if (cmd.add)
        begin
            if (count_reg == CntW'(CAPACITY))
            begin
                status_next = spq_pkg::ST_FULL_DROP;
            end
            else
            begin
                count_next = count_reg + CntW'(1);
            end
        end
        else if (cmd.pop)
        begin
            if (count_reg == '0)
            begin
                status_next = spq_pkg::ST_EMPTY_POP;
            end
            else
            begin
                count_next = count_reg - CntW'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg <= count_next;
            end
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            head_reg      <= nxt[0].full ? nxt[0].value : '0;
            empty_reg     <= (count_next == '0);
            count_out_reg <= spq_pkg::CountW'(count_next);
            status_reg    <= status_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.head_value  = head_reg;
    assign rsp.is_empty    = empty_reg;
    assign rsp.entry_count = count_out_reg;
    assign rsp.status      = status_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(full_vec) == int'(count_reg))
        else $error("entry count disagrees with occupied cells");

    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((full_vec + CAPACITY'(1)) & full_vec) == '0)
        else $error("occupied cells not packed toward the head");

    a_empty_pop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (status_reg == spq_pkg::ST_EMPTY_POP) |-> empty_reg)
        else $error("empty pop reported on a non-empty queue");
`endif

endmodule
